[hdl/ptds_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Periodic task scheduler package
// Shared types and constants for the periodic task due scheduler.
// ----------------------------------------------------------------------------
package ptds_pkg;

	localparam int MAX_RESULTS = 8;

	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_POLL   = 2'd1,
		OP_REPORT = 2'd2,
		OP_QUERY  = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		KIND_ADD_ACK    = 2'd0,
		KIND_DUE        = 2'd1,
		KIND_REPORT_ACK = 2'd2,
		KIND_QUERY      = 2'd3
	} kind_t;

	typedef struct packed {
		opcode_t     opcode;
		logic [31:0] now_us;
		logic [31:0] period_value;
		logic        handler_present;
		logic [2:0]  slot_select;
		logic [31:0] exec_time;
	} req_t;

	typedef struct packed {
		kind_t       result_kind;
		logic        status;
		logic [2:0]  slot_index;
		logic        overran;
		logic [31:0] runs_done;
		logic [31:0] overruns_seen;
		logic [31:0] latest_exec;
		logic [31:0] peak_exec;
		logic [31:0] next_due;
		logic [3:0]  slots_used;
		logic        last_in_run;
	} rsp_t;

	typedef struct packed {
		logic load;
		logic poll_start;
		logic step;
		logic kill;
	} cell_ctl_t;

	typedef struct packed {
		logic        overran;
		logic [31:0] runs;
		logic [31:0] overruns;
		logic [31:0] latest;
		logic [31:0] peak;
		logic [31:0] due;
	} cell_res_t;

endpackage

[hdl/ptds_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one scheduler operation per beat.
// ----------------------------------------------------------------------------
interface ptds_req_if import ptds_pkg::*; ();
	logic valid;
	logic ready;
	req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[hdl/ptds_rsp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries one scheduler result per beat.
// ----------------------------------------------------------------------------
interface ptds_rsp_if import ptds_pkg::*; ();
	logic valid;
	logic ready;
	rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[hdl/ptds_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Task slot cell
// Holds one task slot and acts on the operation while it holds the token, for a poll only when the slot is due.
// ----------------------------------------------------------------------------
module ptds_cell import ptds_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cell_ctl_t   ctl,
	input  req_t        pkt,
	input  logic [31:0] start_now,
	input  logic        en,
	input  logic        inject,
	input  logic        tok_in,
	output logic        tok_out,
	output logic        tok,
	output logic        pend,
	output logic        act,
	output cell_res_t   res
);

	logic [31:0] due_time_q;
	logic [31:0] period_q;
	logic [31:0] runs_q;
	logic [31:0] overruns_q;
	logic [31:0] recent_q;
	logic [31:0] peak_q;
	logic        tok_q;
	logic        pend_q;
	logic        late_q;

	logic        is_poll;
	logic        fire;
	logic [31:0] diff;
	logic [31:0] base;
	logic [31:0] addend;
	logic [31:0] sum;
	cell_res_t   nx;
	logic [31:0] nx_period;

	assign is_poll = (pkt.opcode == OP_POLL);
	assign act     = tok_q & (~is_poll | pend_q);
	assign fire    = act & ctl.step;
	assign diff    = start_now - due_time_q;
	assign base    = (is_poll && !late_q) ? due_time_q : pkt.now_us;
	assign addend  = (pkt.opcode == OP_ADD) ? pkt.period_value : period_q;
	assign sum     = base + addend;

	always_comb begin
		nx.overran  = is_poll & late_q;
		nx.runs     = runs_q;
		nx.overruns = overruns_q;
		nx.latest   = recent_q;
		nx.peak     = peak_q;
		nx.due      = due_time_q;
		nx_period   = period_q;
		unique case (pkt.opcode)
			OP_ADD: begin
				nx_period = pkt.period_value;
				nx.due    = sum;
			end
			OP_POLL: begin
				nx.due  = sum;
				nx.runs = runs_q + 32'd1;
				if (late_q) begin
					nx.overruns = overruns_q + 32'd1;
				end
			end
			OP_REPORT: begin
				nx.latest = pkt.exec_time;
				if (pkt.exec_time > peak_q) begin
					nx.peak = pkt.exec_time;
				end
			end
			OP_QUERY: begin
			end
			default: begin
			end
		endcase
	end

	assign res     = nx;
	assign tok     = tok_q;
	assign pend    = pend_q;
	assign tok_out = tok_q & is_poll & ~(act & ~ctl.step);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			due_time_q <= '0;
			period_q   <= '0;
			runs_q     <= '0;
			overruns_q <= '0;
			recent_q   <= '0;
			peak_q     <= '0;
		end else if (fire) begin
			due_time_q <= nx.due;
			period_q   <= nx_period;
			runs_q     <= nx.runs;
			overruns_q <= nx.overruns;
			recent_q   <= nx.latest;
			peak_q     <= nx.peak;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q  <= 1'b0;
			pend_q <= 1'b0;
			late_q <= 1'b0;
		end else begin
			priority if (ctl.load) begin
				tok_q <= inject;
			end else if (ctl.kill) begin
				tok_q <= 1'b0;
			end else begin
				tok_q <= (tok_q & act & ~ctl.step) | tok_in;
			end
			priority if (ctl.poll_start) begin
				pend_q <= en & ~diff[31];
				late_q <= (diff >= period_q);
			end else if (fire && is_poll) begin
				pend_q <= 1'b0;
			end
		end
	end

endmodule

[hdl/periodic_task_due_scheduler_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Periodic task due scheduler core
// Row of task slot cells walked by a token; one result register on the output.
// ----------------------------------------------------------------------------
// Channel  Modport  Beat
// req      sink     one operation: add, poll, report or query
// rsp      source   one result; last_in_run marks the final one of an operation
//
// Add, report and query put the token on the addressed cell. A poll puts it
// on slot 0; it steps one cell per cycle unless a stalled result holds it,
// until no slot is left due.
// A rejected add or an invalid slot is answered from rej_q, with no token.
// Reset clears all slots; a stalled result holds the token in its cell.
// ----------------------------------------------------------------------------
module periodic_task_due_scheduler_core import ptds_pkg::*; #(
	parameter int NUM_TASKS = 8
) (
	input logic         clk,
	input logic         arst_n,
	ptds_req_if.sink    req,
	ptds_rsp_if.source  rsp
);

	localparam int IW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
	localparam int CW = $clog2(NUM_TASKS + 1);
	localparam int TW = (CW > 3) ? CW : 3;

	req_t          pkt_q;
	logic          rej_q;
	logic [CW-1:0] used_q;
	logic          ovld_q;
	rsp_t          out_q;

	logic [NUM_TASKS-1:0] tok_v;
	logic [NUM_TASKS-1:0] tok_out_v;
	logic [NUM_TASKS-1:0] pend_v;
	logic [NUM_TASKS-1:0] act_v;
	logic [NUM_TASKS-1:0] inject_v;
	logic [NUM_TASKS-1:0] en_v;
	cell_res_t            res_v [NUM_TASKS];

	cell_ctl_t     ctl;
	logic          busy;
	logic          accept;
	logic          rej;
	logic [TW-1:0] tgt;
	logic          step;
	logic          any_act;
	logic          add_fire;
	logic [CW-1:0] used_nx;
	cell_res_t     res_sel;
	logic [IW-1:0] pos;
	rsp_t          o;

	assign busy      = (|tok_v) | rej_q;
	assign req.ready = ~busy;
	assign accept    = req.valid & ~busy;
	assign step      = ~ovld_q | rsp.ready;
	assign any_act   = |act_v;
	assign add_fire  = any_act & step & (pkt_q.opcode == OP_ADD);
	assign used_nx   = used_q + CW'(1);

	always_comb begin
		rej = 1'b0;
		tgt = '0;
		unique case (req.data.opcode)
			OP_ADD: begin
				rej = ~req.data.handler_present || (req.data.period_value == '0) ||
				      (used_q >= CW'(NUM_TASKS));
				tgt = TW'(used_q);
			end
			OP_POLL: begin
				rej = 1'b0;
			end
			OP_REPORT, OP_QUERY: begin
				rej = ~(TW'(req.data.slot_select) < TW'(used_q));
				tgt = TW'(req.data.slot_select);
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		for (int i = 0; i < NUM_TASKS; i++) begin
			if (req.data.opcode == OP_POLL) begin
				inject_v[i] = (i == 0);
			end else begin
				inject_v[i] = ~rej & (tgt == TW'(i));
			end
			en_v[i] = (CW'(i) < used_q) && (i < MAX_RESULTS);
		end
	end

	assign ctl.load       = accept;
	assign ctl.poll_start = accept & (req.data.opcode == OP_POLL);
	assign ctl.step       = step;
	assign ctl.kill       = (pkt_q.opcode == OP_POLL) & ~(|pend_v);

	for (genvar i = 0; i < NUM_TASKS; i++) begin : g_cell
		logic tok_in;
		if (i == 0) begin : g_head
			assign tok_in = 1'b0;
		end else begin : g_link
			assign tok_in = tok_out_v[i-1];
		end
		ptds_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.pkt       (pkt_q),
			.start_now (req.data.now_us),
			.en        (en_v[i]),
			.inject    (inject_v[i]),
			.tok_in    (tok_in),
			.tok_out   (tok_out_v[i]),
			.tok       (tok_v[i]),
			.pend      (pend_v[i]),
			.act       (act_v[i]),
			.res       (res_v[i])
		);
	end

	always_comb begin
		res_sel = '0;
		pos     = '0;
		for (int i = 0; i < NUM_TASKS; i++) begin
			if (act_v[i]) begin
				res_sel = res_sel | res_v[i];
				pos     = pos | IW'(i);
			end
		end
	end

	always_comb begin
		o             = '0;
		o.result_kind = kind_t'(pkt_q.opcode);
		if (rej_q) begin
			o.status      = 1'b1;
			o.slot_index  = (pkt_q.opcode == OP_ADD) ? 3'd0 : pkt_q.slot_select;
			o.slots_used  = 4'(used_q);
			o.last_in_run = 1'b1;
		end else begin
			o.status        = 1'b0;
			o.slot_index    = 3'(pos);
			o.overran       = res_sel.overran;
			o.runs_done     = res_sel.runs;
			o.overruns_seen = res_sel.overruns;
			o.latest_exec   = res_sel.latest;
			o.peak_exec     = res_sel.peak;
			o.next_due      = res_sel.due;
			o.slots_used    = (pkt_q.opcode == OP_ADD) ? 4'(used_nx) : 4'(used_q);
			o.last_in_run   = (pkt_q.opcode != OP_POLL) | ~(|(pend_v & ~act_v));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pkt_q  <= '0;
			rej_q  <= 1'b0;
			used_q <= '0;
		end else begin
			if (accept) begin
				pkt_q <= req.data;
				rej_q <= rej;
			end else if (rej_q && step) begin
				rej_q <= 1'b0;
			end
			if (add_fire) begin
				used_q <= used_nx;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovld_q <= 1'b0;
		end else if (step) begin
			ovld_q <= rej_q | any_act;
		end
	end

	always_ff @(posedge clk) begin
		if (step && (rej_q || any_act)) begin
			out_q <= o;
		end
	end

	assign rsp.valid = ovld_q;
	assign rsp.data  = out_q;

	// The walking token exists at most once in the row.
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok_v))
		else $error("more than one cell holds the token");

	// A pending rejection never coexists with a token in the row.
	a_rej_no_token: assert property (@(posedge clk) disable iff (!arst_n)
		rej_q |-> (tok_v == '0))
		else $error("rejection pending while a cell holds the token");

	// The slot count never exceeds the table size.
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CW'(NUM_TASKS))
		else $error("slot count beyond table size");

	// Every add that is not rejected advances the slot count by one.
	a_add_count: assert property (@(posedge clk) disable iff (!arst_n)
		add_fire |=> (used_q == $past(used_nx)))
		else $error("slot count did not advance after an add");

	// A due result is never flagged as rejected.
	a_due_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && (rsp.data.result_kind == KIND_DUE)) |-> !rsp.data.status)
		else $error("due result carries a reject status");

endmodule

[tb/sv/ptds_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Periodic task scheduler checker
// Watches the request and result channels of the scheduler core. It keeps its
// own copy of the slot table, predicts the results of every accepted request
// beat and compares each accepted result beat field by field with the oldest
// prediction.
// ----------------------------------------------------------------------------
module ptds_checker import ptds_pkg::*; #(
	parameter int NUM_TASKS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	ptds_req_if         req_mon,
	ptds_rsp_if         rsp_mon,
	output int unsigned mismatch_count,
	output int unsigned answers_owed,
	output int unsigned beats_checked,
	output int unsigned dispatches,
	output int unsigned realignments
);

	localparam int PRINT_CAP = 50;

	logic [31:0] due_at    [NUM_TASKS];
	logic [31:0] period_of [NUM_TASKS];
	logic [31:0] runs      [NUM_TASKS];
	logic [31:0] overruns  [NUM_TASKS];
	logic [31:0] exec_last [NUM_TASKS];
	logic [31:0] exec_peak [NUM_TASKS];
	logic [3:0]  slots_in_use;

	rsp_t predicted_results[$];

	function automatic rsp_t slot_result(kind_t kind, logic [2:0] slot, logic over);
		rsp_t r;
		r               = '0;
		r.result_kind   = kind;
		r.slot_index    = slot;
		r.overran       = over;
		r.runs_done     = runs[slot];
		r.overruns_seen = overruns[slot];
		r.latest_exec   = exec_last[slot];
		r.peak_exec     = exec_peak[slot];
		r.next_due      = due_at[slot];
		r.slots_used    = slots_in_use;
		return r;
	endfunction

	function automatic rsp_t refused_result(kind_t kind, logic [2:0] slot);
		rsp_t r;
		r             = '0;
		r.result_kind = kind;
		r.status      = 1'b1;
		r.slot_index  = slot;
		r.slots_used  = slots_in_use;
		return r;
	endfunction

	task automatic report_mismatch(input string what);
		if (mismatch_count < PRINT_CAP) begin
			$display("%t mismatch on result beat %0d: %s", $realtime, beats_checked, what);
		end
		mismatch_count++;
	endtask

	task automatic match_field(input string name, input logic [31:0] got,
		input logic [31:0] want);
		if (got !== want) begin
			report_mismatch($sformatf("%s is %h, predicted %h", name, got, want));
		end
	endtask

	task automatic advance_schedule(input req_t op);
		int unsigned first;
		int unsigned scan;
		logic [31:0] lag;
		logic        over;
		logic [2:0]  s;
		kind_t       kind;
		first = predicted_results.size();
		case (op.opcode)
			OP_ADD: begin
				if (!op.handler_present || op.period_value == '0
					|| slots_in_use >= NUM_TASKS) begin
					predicted_results.push_back(refused_result(KIND_ADD_ACK, 3'd0));
				end else begin
					s            = slots_in_use[2:0];
					period_of[s] = op.period_value;
					due_at[s]    = op.now_us + op.period_value;
					slots_in_use = slots_in_use + 4'd1;
					predicted_results.push_back(slot_result(KIND_ADD_ACK, s, 1'b0));
				end
			end
			OP_POLL: begin
				for (scan = 0; scan < slots_in_use && scan < MAX_RESULTS; scan++) begin
					lag = op.now_us - due_at[scan];
					if (!lag[31]) begin
						over = 1'b0;
						if (lag >= period_of[scan]) begin
							overruns[scan] = overruns[scan] + 32'd1;
							due_at[scan]   = op.now_us + period_of[scan];
							over           = 1'b1;
							realignments++;
						end else begin
							due_at[scan] = due_at[scan] + period_of[scan];
						end
						runs[scan] = runs[scan] + 32'd1;
						dispatches++;
						predicted_results.push_back(slot_result(KIND_DUE, scan[2:0], over));
					end
				end
			end
			default: begin
				kind = (op.opcode == OP_REPORT) ? KIND_REPORT_ACK : KIND_QUERY;
				s    = op.slot_select;
				if ({1'b0, s} >= slots_in_use) begin
					predicted_results.push_back(refused_result(kind, s));
				end else begin
					if (op.opcode == OP_REPORT) begin
						exec_last[s] = op.exec_time;
						if (op.exec_time > exec_peak[s]) begin
							exec_peak[s] = op.exec_time;
						end
					end
					predicted_results.push_back(slot_result(kind, s, 1'b0));
				end
			end
		endcase
		if (predicted_results.size() > first) begin
			predicted_results[predicted_results.size() - 1].last_in_run = 1'b1;
		end
	endtask

	task automatic check_result(input rsp_t got);
		rsp_t want;
		if (predicted_results.size() == 0) begin
			report_mismatch("result beat with nothing outstanding");
		end else begin
			want = predicted_results.pop_front();
			match_field("result_kind", 32'(got.result_kind), 32'(want.result_kind));
			match_field("status", 32'(got.status), 32'(want.status));
			match_field("slot_index", 32'(got.slot_index), 32'(want.slot_index));
			match_field("overran", 32'(got.overran), 32'(want.overran));
			match_field("runs_done", got.runs_done, want.runs_done);
			match_field("overruns_seen", got.overruns_seen, want.overruns_seen);
			match_field("latest_exec", got.latest_exec, want.latest_exec);
			match_field("peak_exec", got.peak_exec, want.peak_exec);
			match_field("next_due", got.next_due, want.next_due);
			match_field("slots_used", 32'(got.slots_used), 32'(want.slots_used));
			match_field("last_in_run", 32'(got.last_in_run), 32'(want.last_in_run));
		end
		beats_checked++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_TASKS; i++) begin
				due_at[i]    = '0;
				period_of[i] = '0;
				runs[i]      = '0;
				overruns[i]  = '0;
				exec_last[i] = '0;
				exec_peak[i] = '0;
			end
			slots_in_use = '0;
			predicted_results.delete();
			mismatch_count = 0;
			answers_owed   = 0;
			beats_checked  = 0;
			dispatches     = 0;
			realignments   = 0;
		end else begin
			if (req_mon.valid && req_mon.ready) begin
				advance_schedule(req_mon.data);
			end
			if (rsp_mon.valid && rsp_mon.ready) begin
				check_result(rsp_mon.data);
			end
			answers_owed = predicted_results.size();
		end
	end

endmodule

[tb/sv/periodic_task_due_scheduler_core_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Periodic task scheduler core test
// Drives add, poll, report and query operations into the scheduler core:
// a directed opening over empty, rejected, wrapping and overrun cases, then
// random operations that follow a moving microsecond clock with some noise.
// Both channels idle at random in the first two of three phases; a checker
// beside the core predicts and compares every result beat.
// ----------------------------------------------------------------------------
module periodic_task_due_scheduler_core_test;
	import ptds_pkg::*;

	localparam int NUM_TASKS    = 8;
	localparam int CLK_PERIOD   = 12;
	localparam int RANDOM_ITEMS = 350;
	localparam int DRAIN_CYCLES = 32;
	localparam int CYCLE_LIMIT  = 400000;

	logic        clk = 1'b0;
	logic        arst_n;
	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	int unsigned cycle_count = 0;
	int unsigned op_tally[4];
	logic [31:0] sim_now_us;

	int unsigned mismatch_count;
	int unsigned answers_owed;
	int unsigned beats_checked;
	int unsigned dispatches;
	int unsigned realignments;

	ptds_req_if req();
	ptds_rsp_if rsp();

	periodic_task_due_scheduler_core #(.NUM_TASKS(NUM_TASKS)) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	ptds_checker #(.NUM_TASKS(NUM_TASKS)) u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_mon        (req),
		.rsp_mon        (rsp),
		.mismatch_count (mismatch_count),
		.answers_owed   (answers_owed),
		.beats_checked  (beats_checked),
		.dispatches     (dispatches),
		.realignments   (realignments)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	always @(posedge clk) begin
		rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				answers_owed);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic req_t make_op(opcode_t op, logic [31:0] now, logic [31:0] period,
		logic hnd, logic [2:0] sel, logic [31:0] ex);
		req_t r;
		r.opcode          = op;
		r.now_us          = now;
		r.period_value    = period;
		r.handler_present = hnd;
		r.slot_select     = sel;
		r.exec_time       = ex;
		return r;
	endfunction

	task automatic send_op(input req_t item);
		while ($urandom_range(99) < send_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.data  <= item;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		op_tally[item.opcode]++;
	endtask

	initial begin
		int unsigned k;
		logic        noisy;
		int unsigned pick;
		opcode_t     op;
		logic [31:0] now;
		logic [31:0] per;
		logic        hnd;
		logic [2:0]  sel;
		logic [31:0] ex;

		arst_n        = 1'b0;
		req.valid     = 1'b0;
		req.data      = '0;
		rsp.ready     = 1'b0;
		send_idle_pct = 14;
		recv_idle_pct = 70;
		for (int i = 0; i < 4; i++) op_tally[i] = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_op(make_op(OP_QUERY, 32'h0, 32'h0, 1'b0, 3'd0, 32'h0));
		send_op(make_op(OP_REPORT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 3'd7, 32'hFFFF_FFFF));
		send_op(make_op(OP_POLL, 32'h0, 32'h0, 1'b0, 3'd0, 32'h0));
		send_op(make_op(OP_ADD, 32'hFFFF_FF00, 32'h100, 1'b0, 3'd0, 32'h0));
		send_op(make_op(OP_ADD, 32'hFFFF_FF00, 32'h0, 1'b1, 3'd0, 32'h0));
		send_op(make_op(OP_ADD, 32'hFFFF_FF00, 32'h100, 1'b1, 3'd0, 32'h0));
		send_op(make_op(OP_ADD, 32'hFFFF_FF00, 32'hFFFF_FFFF, 1'b1, 3'd0, 32'h0));
		send_op(make_op(OP_ADD, 32'hFFFF_FF00, 32'h1, 1'b1, 3'd0, 32'h0));
		send_op(make_op(OP_POLL, 32'hFFFF_FF00, 32'h0, 1'b0, 3'd0, 32'h0));
		send_op(make_op(OP_POLL, 32'hFFFF_FFFF, 32'h0, 1'b0, 3'd0, 32'h0));
		send_op(make_op(OP_POLL, 32'h0, 32'h0, 1'b0, 3'd0, 32'h0));
		send_op(make_op(OP_REPORT, 32'h0, 32'h0, 1'b0, 3'd0, 32'h0));
		send_op(make_op(OP_REPORT, 32'h0, 32'h0, 1'b0, 3'd0, 32'hFFFF_FFFF));
		send_op(make_op(OP_REPORT, 32'h0, 32'h0, 1'b0, 3'd0, 32'h5));
		send_op(make_op(OP_QUERY, 32'h0, 32'h0, 1'b0, 3'd0, 32'h0));
		send_op(make_op(OP_QUERY, 32'h0, 32'h0, 1'b0, 3'd3, 32'h0));
		send_op(make_op(OP_REPORT, 32'h0, 32'h0, 1'b0, 3'd3, 32'h77));
		send_op(make_op(OP_POLL, 32'h300, 32'h0, 1'b0, 3'd0, 32'h0));
		send_op(make_op(OP_QUERY, 32'h0, 32'h0, 1'b0, 3'd2, 32'h0));
		send_op(make_op(OP_POLL, 32'h300, 32'h0, 1'b0, 3'd0, 32'h0));

		sim_now_us = 32'h300;
		for (k = 0; k < RANDOM_ITEMS; k++) begin
			if (k == RANDOM_ITEMS / 3) begin
				send_idle_pct = 70;
				recv_idle_pct = 14;
			end
			if (k == 2 * RANDOM_ITEMS / 3) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			noisy = ($urandom_range(9) == 0);
			pick  = $urandom_range(99);
			now   = $urandom;
			per   = $urandom;
			hnd   = $urandom_range(1);
			sel   = $urandom_range(7);
			ex    = $urandom;
			if (pick < 12) begin
				op  = OP_ADD;
				now = sim_now_us;
				hnd = ($urandom_range(9) != 0);
				if (!noisy) begin
					per = ($urandom_range(7) == 0) ? $urandom : $urandom_range(400, 1);
				end else if ($urandom_range(1)) begin
					per = '0;
				end
			end else if (pick < 55) begin
				op = OP_POLL;
				if (noisy) begin
					sim_now_us = $urandom;
				end else begin
					sim_now_us = sim_now_us + (($urandom_range(3) == 0) ?
						$urandom_range(2000) : $urandom_range(120));
				end
				now = sim_now_us;
			end else if (pick < 78) begin
				op = OP_REPORT;
				if (!noisy) ex = $urandom_range(1000);
			end else begin
				op = OP_QUERY;
			end
			send_op(make_op(op, now, per, hnd, sel, ex));
		end
		req.valid <= 1'b0;

		do @(negedge clk); while (answers_owed != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d adds, %0d polls, %0d reports and %0d queries; %0d result beats checked.",
			op_tally[OP_ADD], op_tally[OP_POLL], op_tally[OP_REPORT], op_tally[OP_QUERY],
			beats_checked);
		$display("Polls dispatched %0d due tasks, %0d of them realigned after an overrun.",
			dispatches, realignments);
		if (mismatch_count == 0 && answers_owed == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
